/* hdl/array_linked_list_engine_defines.svh */
// Assertion macros for the port checker of the linked list engine.
`ifndef ARRAY_LINKED_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LINKED_LIST_ENGINE_DEFINES_SVH

// The antecedent and the consequent hold in the same cycle.
`define ALLE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("linked list engine check failed");

// The consequent holds in the cycle after the antecedent.
`define ALLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("linked list engine check failed");

`endif

/* hdl/alle_pkg.sv */
// Package of the linked list engine: sizes, codes, transfer types and helpers.
package alle_pkg;

  localparam int NODES  = 16;
  localparam int IDX_W  = $clog2(NODES);
  localparam int LINK_W = IDX_W + 1;
  localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(NODES);

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_TRAVERSE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NO_SUCC = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         command;
    logic               at_head;
    logic [3:0]         pred_index;
    logic signed [31:0] student_id;
    logic [31:0]        grade_bits;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         node_index;
    logic signed [31:0] out_student_id;
    logic [31:0]        out_grade_bits;
    logic [3:0]         next_index;
    logic               next_is_end;
    logic               last;
  } res_t;

  // A link at or above the pool size is treated as the end of a list.
  function automatic logic link_is_nil(logic [LINK_W-1:0] link);
    return link >= LINK_NIL;
  endfunction

  function automatic logic [LINK_W-1:0] link_clean(logic [LINK_W-1:0] link);
    return link_is_nil(link) ? LINK_NIL : link;
  endfunction

  // Low four bits of a node index, as the result fields carry it.
  function automatic logic [3:0] idx_to_field(logic [IDX_W-1:0] idx);
    logic [IDX_W+3:0] wide;
    wide = {4'b0000, idx};
    return wide[3:0];
  endfunction

  // Predecessor field reduced modulo the pool size by repeated subtraction.
  function automatic logic [IDX_W-1:0] pred_wrap(logic [3:0] pred);
    logic [7:0] v;
    v = {4'b0000, pred};
    for (int i = 0; i < 8; i++) begin
      if (v >= 8'(NODES)) begin
        v = v - 8'(NODES);
      end
    end
    return v[IDX_W-1:0];
  endfunction

endpackage

/* hdl/array_linked_list_engine.sv */
// Linked list engine: node pool with a list and a free list on one link memory.
// A command is taken when start is high and busy is low. Results appear on
// res_o for one cycle with res_valid_o high and cannot be held off. Insert
// reads the free node's link and links the node in at the head, or reads the
// predecessor's link and then writes the node's and the predecessor's links.
// Delete reads the head's link, or the predecessor's and the successor's,
// relinks the list and puts the removed node on the free list. A full pool or
// an empty list is answered from the idle state, a missing successor once the
// predecessor's link is read. Traverse gives one result per list node (at
// most NODES), back to back after the first read. The link memory does one
// read and one write per cycle with registered read data. The last result of
// a command is shown while busy is low, so the next command can be started
// there. Link entries that were never written read as their reset chain
// through per-entry valid bits; no clearing pass runs after reset.
module array_linked_list_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  alle_pkg::cmd_t   cmd_i,
  output logic             res_valid_o,
  output alle_pkg::res_t   res_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_A,
    S_INS_B,
    S_INS_C,
    S_DEL_H,
    S_DEL_P1,
    S_DEL_P2,
    S_DEL_P3,
    S_TRV
  } state_e;

  state_e state_q, state_d;

  logic [alle_pkg::LINK_W-1:0] list_head_q, list_head_d;
  logic [alle_pkg::LINK_W-1:0] free_head_q, free_head_d;
  logic [alle_pkg::IDX_W-1:0]  cur_q, cur_d;
  logic [alle_pkg::IDX_W-1:0]  pred_q, pred_d;
  logic [alle_pkg::IDX_W-1:0]  k_q, k_d;
  logic                        at_head_q, at_head_d;
  logic                        res_valid_q, res_valid_d;
  alle_pkg::res_t              res_q, res_d;

  // Link memory with valid bits that stand in for the reset chain.
  logic [alle_pkg::LINK_W-1:0] link_mem [alle_pkg::NODES];
  logic [alle_pkg::NODES-1:0]  link_vld_q;
  logic [alle_pkg::LINK_W-1:0] link_rd_q;
  logic [alle_pkg::IDX_W-1:0]  link_raddr;
  logic                        link_we;
  logic [alle_pkg::IDX_W-1:0]  link_waddr;
  logic [alle_pkg::LINK_W-1:0] link_wdata;

  // Payload memories.
  logic signed [31:0]          sid_mem [alle_pkg::NODES];
  logic [31:0]                 grd_mem [alle_pkg::NODES];
  logic signed [31:0]          sid_rd_q;
  logic [31:0]                 grd_rd_q;
  logic [alle_pkg::IDX_W-1:0]  pay_raddr;
  logic                        pay_we;

  logic [alle_pkg::LINK_W-1:0] rd_link;
  logic [alle_pkg::IDX_W-1:0]  rd_idx;
  logic                        rd_nil;
  logic [alle_pkg::IDX_W-1:0]  list_idx;
  logic [alle_pkg::IDX_W-1:0]  free_idx;
  logic                        trv_fin;

  assign rd_link  = alle_pkg::link_clean(link_rd_q);
  assign rd_idx   = link_rd_q[alle_pkg::IDX_W-1:0];
  assign rd_nil   = alle_pkg::link_is_nil(link_rd_q);
  assign list_idx = list_head_q[alle_pkg::IDX_W-1:0];
  assign free_idx = free_head_q[alle_pkg::IDX_W-1:0];
  assign trv_fin  = rd_nil || (k_q == alle_pkg::IDX_W'(alle_pkg::NODES - 1));

  always_comb begin
    state_d     = state_q;
    list_head_d = list_head_q;
    free_head_d = free_head_q;
    cur_d       = cur_q;
    pred_d      = pred_q;
    k_d         = k_q;
    at_head_d   = at_head_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    link_raddr  = cur_q;
    link_we     = 1'b0;
    link_waddr  = cur_q;
    link_wdata  = list_head_q;
    pay_raddr   = cur_q;
    pay_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          at_head_d = cmd_i.at_head;
          pred_d    = alle_pkg::pred_wrap(cmd_i.pred_index);
          unique case (cmd_i.command)
            alle_pkg::CMD_INSERT: begin
              if (alle_pkg::link_is_nil(free_head_q)) begin
                res_valid_d = 1'b1;
                res_d.status = alle_pkg::ST_FULL;
                res_d.last   = 1'b1;
              end else begin
                cur_d      = free_idx;
                link_raddr = free_idx;
                pay_we     = 1'b1;
                state_d    = S_INS_A;
              end
            end
            alle_pkg::CMD_DELETE: begin
              if (alle_pkg::link_is_nil(list_head_q)) begin
                res_valid_d = 1'b1;
                res_d.status = alle_pkg::ST_EMPTY;
                res_d.last   = 1'b1;
              end else if (cmd_i.at_head) begin
                cur_d      = list_idx;
                link_raddr = list_idx;
                state_d    = S_DEL_H;
              end else begin
                link_raddr = pred_d;
                state_d    = S_DEL_P1;
              end
            end
            alle_pkg::CMD_TRAVERSE: begin
              if (alle_pkg::link_is_nil(list_head_q)) begin
                res_valid_d = 1'b1;
                res_d.status = alle_pkg::ST_EMPTY;
                res_d.last   = 1'b1;
              end else begin
                cur_d      = list_idx;
                k_d        = '0;
                link_raddr = list_idx;
                pay_raddr  = list_idx;
                state_d    = S_TRV;
              end
            end
            default: begin
              // The unused code is taken and dropped without a result.
            end
          endcase
        end
      end

      S_INS_A: begin
        free_head_d = rd_link;
        if (at_head_q) begin
          link_we     = 1'b1;
          link_waddr  = cur_q;
          link_wdata  = list_head_q;
          list_head_d = {1'b0, cur_q};
          res_valid_d = 1'b1;
          res_d.status     = alle_pkg::ST_OK;
          res_d.node_index = alle_pkg::idx_to_field(cur_q);
          res_d.last       = 1'b1;
          state_d     = S_IDLE;
        end else begin
          link_raddr = pred_q;
          state_d    = S_INS_B;
        end
      end

      S_INS_B: begin
        link_we    = 1'b1;
        link_waddr = cur_q;
        link_wdata = rd_link;
        state_d    = S_INS_C;
      end

      S_INS_C: begin
        link_we     = 1'b1;
        link_waddr  = pred_q;
        link_wdata  = {1'b0, cur_q};
        res_valid_d = 1'b1;
        res_d.status     = alle_pkg::ST_OK;
        res_d.node_index = alle_pkg::idx_to_field(cur_q);
        res_d.last       = 1'b1;
        state_d     = S_IDLE;
      end

      S_DEL_H: begin
        list_head_d = rd_link;
        link_we     = 1'b1;
        link_waddr  = cur_q;
        link_wdata  = free_head_q;
        free_head_d = {1'b0, cur_q};
        res_valid_d = 1'b1;
        res_d.status     = alle_pkg::ST_OK;
        res_d.node_index = alle_pkg::idx_to_field(cur_q);
        res_d.last       = 1'b1;
        state_d     = S_IDLE;
      end

      S_DEL_P1: begin
        if (rd_nil) begin
          res_valid_d = 1'b1;
          res_d.status = alle_pkg::ST_NO_SUCC;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cur_d      = rd_idx;
          link_raddr = rd_idx;
          state_d    = S_DEL_P2;
        end
      end

      S_DEL_P2: begin
        link_we    = 1'b1;
        link_waddr = pred_q;
        link_wdata = rd_link;
        state_d    = S_DEL_P3;
      end

      S_DEL_P3: begin
        link_we     = 1'b1;
        link_waddr  = cur_q;
        link_wdata  = free_head_q;
        free_head_d = {1'b0, cur_q};
        res_valid_d = 1'b1;
        res_d.status     = alle_pkg::ST_OK;
        res_d.node_index = alle_pkg::idx_to_field(cur_q);
        res_d.last       = 1'b1;
        state_d     = S_IDLE;
      end

      S_TRV: begin
        res_valid_d = 1'b1;
        res_d.status         = alle_pkg::ST_OK;
        res_d.node_index     = alle_pkg::idx_to_field(cur_q);
        res_d.out_student_id = sid_rd_q;
        res_d.out_grade_bits = grd_rd_q;
        res_d.next_index     = rd_nil ? 4'd0 : alle_pkg::idx_to_field(rd_idx);
        res_d.next_is_end    = rd_nil;
        res_d.last           = trv_fin;
        if (trv_fin) begin
          state_d = S_IDLE;
        end else begin
          cur_d      = rd_idx;
          k_d        = k_q + alle_pkg::IDX_W'(1);
          link_raddr = rd_idx;
          pay_raddr  = rd_idx;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      list_head_q <= alle_pkg::LINK_NIL;
      free_head_q <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      cur_q       <= '0;
      pred_q      <= '0;
      k_q         <= '0;
      at_head_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      list_head_q <= list_head_d;
      free_head_q <= free_head_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
      cur_q       <= cur_d;
      pred_q      <= pred_d;
      k_q         <= k_d;
      at_head_q   <= at_head_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
    end else if (link_we) begin
      link_vld_q[link_waddr] <= 1'b1;
    end
  end

  // An entry that was never written reads as a link to the next node.
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_q <= link_vld_q[link_raddr] ? link_mem[link_raddr]
                                        : {1'b0, link_raddr} + alle_pkg::LINK_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      sid_mem[free_idx] <= cmd_i.student_id;
      grd_mem[free_idx] <= cmd_i.grade_bits;
    end
    sid_rd_q <= sid_mem[pay_raddr];
    grd_rd_q <= grd_mem[pay_raddr];
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* hdl/alle_checker.sv */
// Port checker of the linked list engine, bound to the top level.
`include "array_linked_list_engine_defines.svh"

module alle_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_i,
  input alle_pkg::cmd_t cmd_i,
  input logic           res_valid_i,
  input alle_pkg::res_t res_i
);

  logic trv_take;
  logic mid_stream;

  assign trv_take   = start_i && !busy_i && (cmd_i.command == alle_pkg::CMD_TRAVERSE);
  assign mid_stream = res_valid_i && !res_i.last;

  // Every status other than ok closes the command.
  `ALLE_ASSERT_SAME(a_err_is_last, res_valid_i && (res_i.status != alle_pkg::ST_OK), res_i.last)
  // A traversal delivers its nodes in back-to-back cycles.
  `ALLE_ASSERT_NEXT(a_stream_gapless, mid_stream, res_valid_i)
  // The block stays busy while a traversal is still delivering.
  `ALLE_ASSERT_SAME(a_stream_busy, mid_stream, busy_i && !res_i.next_is_end)
  // A traversal is either under way or answered as empty in the cycle after it is taken.
  `ALLE_ASSERT_NEXT(a_trv_reacts, trv_take, busy_i || res_valid_i)

endmodule

bind array_linked_list_engine alle_checker u_alle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start),
  .busy_i      (busy),
  .cmd_i       (cmd_i),
  .res_valid_i (res_valid_o),
  .res_i       (res_o)
);
